FILE: sv/tcw_pkg.sv
// shared constants for the texture coordinate wrap block
// store geometry, coordinate and size widths, register indexes, wrap mode codes
// no dependencies
package tcw_pkg;

	localparam int TEX_DIM    = 64;
	localparam int COORD_BITS = 16;

	// texel address bits for one axis, store depth is TEX_DIM squared
	localparam int AXIS_BITS  = $clog2(TEX_DIM);
	localparam int ADDR_BITS  = 2 * AXIS_BITS;
	localparam int STORE_DEPTH = TEX_DIM * TEX_DIM;

	// size in use holds 1..TEX_DIM, the mirrored period holds up to 2*TEX_DIM
	localparam int SIZE_BITS  = $clog2(TEX_DIM + 1);
	localparam int MOD_BITS   = SIZE_BITS + 1;

	// remainder pipeline: bits of the coordinate consumed per stage
	localparam int REM_STEPS  = 4;
	localparam int REM_STAGES = (COORD_BITS + REM_STEPS - 1) / REM_STEPS;

	localparam int CFG_REG_BITS = 7;
	localparam int MODE_BITS    = 2;
	localparam int TEXEL_BITS   = 8;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [TEXEL_BITS-1:0] texel_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_TEX_ROWS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TEX_COLS  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_MODE = 2'd2;

	localparam logic [MODE_BITS-1:0] WRAP_CLAMP  = 2'd0;
	localparam logic [MODE_BITS-1:0] WRAP_REPEAT = 2'd1;
	localparam logic [MODE_BITS-1:0] WRAP_MIRROR = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

endpackage

FILE: sv/tcw_rem_pipe.sv
// pipelined remainder of one coordinate by a narrow modulus
// restoring long division, REM_STEPS coordinate bits per stage, raw coordinate carried along
// depends on tcw_pkg
module tcw_rem_pipe import tcw_pkg::*; (
	input  logic                  clk,
	input  logic [REM_STAGES-1:0] ld,
	input  logic [MOD_BITS-1:0]   modulus,
	input  coord_t                coord_in,
	output logic [MOD_BITS-1:0]   rem,
	output coord_t                coord_out
);

	localparam int PAD_BITS = REM_STAGES * REM_STEPS;

	logic [MOD_BITS-1:0] rem_q   [REM_STAGES];
	coord_t              coord_q [REM_STAGES];

	// one restoring step, remainder stays below the modulus
	function automatic logic [MOD_BITS-1:0] rem_step(input logic [MOD_BITS-1:0] r,
			input logic b, input logic [MOD_BITS-1:0] m);
		logic [MOD_BITS:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[MOD_BITS-1:0];
	endfunction

	genvar k;
	generate
		for (k = 0; k < REM_STAGES; k++) begin : g_stage
			logic [MOD_BITS-1:0] rem_src;
			coord_t              coord_src;
			logic [PAD_BITS-1:0] bits_src;
			logic [MOD_BITS-1:0] rem_nxt;

			if (k == 0) begin : g_first
				assign rem_src   = '0;
				assign coord_src = coord_in;
			end else begin : g_next
				assign rem_src   = rem_q[k-1];
				assign coord_src = coord_q[k-1];
			end

			assign bits_src = PAD_BITS'(coord_src);

			always_comb begin
				rem_nxt = rem_src;
				for (int j = 0; j < REM_STEPS; j++) begin
					rem_nxt = rem_step(rem_nxt, bits_src[PAD_BITS-1-k*REM_STEPS-j], modulus);
				end
			end

			always_ff @(posedge clk) begin
				if (ld[k]) begin
					rem_q[k]   <= rem_nxt;
					coord_q[k] <= coord_src;
				end
			end
		end
	endgenerate

	assign rem       = rem_q[REM_STAGES-1];
	assign coord_out = coord_q[REM_STAGES-1];

endmodule

FILE: sv/texture_coordinate_wrap_top.sv
// texture coordinate wrap: byte texel store with clamp, repeat and mirrored repeat addressing
// top level, holds the configuration, the item pipeline and the texel memory
// depends on tcw_pkg and tcw_rem_pipe
//
// input channel (in_valid / in_stall): func, row, col, texel_in. a write item stores
// texel_in at (row, col) when inside the configured size and gives no result; a fetch
// item maps (row, col) by the wrap mode and returns one texel on the output channel
// (out_valid / out_stall, field texel).
// configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): 0 tex_rows,
// 1 tex_cols, 2 wrap_mode; cfg_ready is always high. write it only when no item is in flight.
// throughput: one item per cycle while the receiver does not stall. a fetch accepted at the
// input passes the REM_STAGES remainder stages, then one mapping stage and one memory read
// into the output register, and only then shows its texel.
// the remainder stages take 4 coordinate bits each.
// writes and reads reach the memory in item order at the same stage, so a fetch always
// sees every earlier write.
// reset clears the pipeline valids and sets rows = 1, cols = 1, clamp mode. the texel
// memory is not cleared. while the receiver stalls, the pipeline keeps moving until its
// bubbles are filled; only then is in_stall raised.
module texture_coordinate_wrap_top import tcw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  coord_t                  row,
	input  coord_t                  col,
	input  texel_t                  texel_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output texel_t                  texel,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_REG_BITS-1:0] cfg_data
);

	// configuration
	logic [CFG_REG_BITS-1:0] rows_q, cols_q;
	logic [MODE_BITS-1:0]    mode_q;
	logic [SIZE_BITS-1:0]    n_rows, n_cols;
	logic [MOD_BITS-1:0]     m_rows, m_cols;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_REG_BITS'(1);
			cols_q <= CFG_REG_BITS'(1);
			mode_q <= WRAP_CLAMP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TEX_ROWS:  rows_q <= cfg_data;
				REG_TEX_COLS:  cols_q <= cfg_data;
				REG_WRAP_MODE: mode_q <= cfg_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [SIZE_BITS-1:0] size_in_use(input logic [CFG_REG_BITS-1:0] v);
		logic [SIZE_BITS-1:0] s;
		if (v == '0) begin
			s = SIZE_BITS'(1);
		end else if (32'(v) > TEX_DIM) begin
			s = SIZE_BITS'(TEX_DIM);
		end else begin
			s = SIZE_BITS'(v);
		end
		return s;
	endfunction

	assign n_rows = size_in_use(rows_q);
	assign n_cols = size_in_use(cols_q);
	// mirrored repeat folds over a period of twice the size
	assign m_rows = (mode_q == WRAP_MIRROR) ? {n_rows, 1'b0} : {1'b0, n_rows};
	assign m_cols = (mode_q == WRAP_MIRROR) ? {n_cols, 1'b0} : {1'b0, n_cols};

	// remainder stages
	logic                  div_vld_q  [REM_STAGES];
	logic                  div_func_q [REM_STAGES];
	texel_t                div_data_q [REM_STAGES];
	logic [REM_STAGES-1:0] div_rdy;
	logic                  rdy_s5, rdy_s6;

	logic                  vld_s5;
	logic                  wr_s5;
	logic                  ok_s5;
	logic [ADDR_BITS-1:0]  addr_s5;
	texel_t                data_s5;
	logic                  go_s5;

	logic                  vld_s6;
	texel_t                texel_s6;

	assign rdy_s6 = !vld_s6 || !out_stall;
	// a write leaves the mapping stage without needing the output register
	assign rdy_s5 = !vld_s5 || wr_s5 || rdy_s6;
	assign go_s5  = vld_s5 && (wr_s5 || rdy_s6);

	always_comb begin
		div_rdy[REM_STAGES-1] = !div_vld_q[REM_STAGES-1] || rdy_s5;
		for (int k = REM_STAGES - 2; k >= 0; k--) begin
			div_rdy[k] = !div_vld_q[k] || div_rdy[k+1];
		end
	end

	assign in_stall = !div_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REM_STAGES; k++) begin
				div_vld_q[k] <= 1'b0;
			end
		end else begin
			if (div_rdy[0]) begin
				div_vld_q[0] <= in_valid;
			end
			for (int k = 1; k < REM_STAGES; k++) begin
				if (div_rdy[k]) begin
					div_vld_q[k] <= div_vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_rdy[0]) begin
			div_func_q[0] <= func;
			div_data_q[0] <= texel_in;
		end
		for (int k = 1; k < REM_STAGES; k++) begin
			if (div_rdy[k]) begin
				div_func_q[k] <= div_func_q[k-1];
				div_data_q[k] <= div_data_q[k-1];
			end
		end
	end

	logic [MOD_BITS-1:0] rem_row, rem_col;
	coord_t              crd_row, crd_col;

	tcw_rem_pipe u_rem_row (
		.clk       (clk),
		.ld        (div_rdy),
		.modulus   (m_rows),
		.coord_in  (row),
		.rem       (rem_row),
		.coord_out (crd_row)
	);

	tcw_rem_pipe u_rem_col (
		.clk       (clk),
		.ld        (div_rdy),
		.modulus   (m_cols),
		.coord_in  (col),
		.rem       (rem_col),
		.coord_out (crd_col)
	);

	// map one axis into the texture
	function automatic logic [AXIS_BITS-1:0] wrap_axis(input logic [MODE_BITS-1:0] mode,
			input coord_t c, input logic [MOD_BITS-1:0] r, input logic [SIZE_BITS-1:0] n);
		logic [MOD_BITS-1:0] m;
		m = '0;
		case (mode)
			WRAP_REPEAT: m = r;
			WRAP_MIRROR: m = (r < {1'b0, n}) ? r : ({n, 1'b0} - MOD_BITS'(1) - r);
			default:     m = (c < COORD_BITS'(n)) ? MOD_BITS'(c) : MOD_BITS'(n - SIZE_BITS'(1));
		endcase
		return m[AXIS_BITS-1:0];
	endfunction

	logic                 wr_nxt, ok_nxt;
	logic [ADDR_BITS-1:0] addr_nxt;

	always_comb begin
		wr_nxt = (div_func_q[REM_STAGES-1] == FUNC_WRITE);
		ok_nxt = (crd_row < COORD_BITS'(n_rows)) && (crd_col < COORD_BITS'(n_cols));
		if (wr_nxt) begin
			addr_nxt = {crd_row[AXIS_BITS-1:0], crd_col[AXIS_BITS-1:0]};
		end else begin
			addr_nxt = {wrap_axis(mode_q, crd_row, rem_row, n_rows),
				wrap_axis(mode_q, crd_col, rem_col, n_cols)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= div_vld_q[REM_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			wr_s5   <= wr_nxt;
			ok_s5   <= ok_nxt;
			addr_s5 <= addr_nxt;
			data_s5 <= div_data_q[REM_STAGES-1];
		end
	end

	// texel memory, one access per cycle, read data lands in the output register
	texel_t tex_mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (go_s5) begin
			if (wr_s5) begin
				if (ok_s5) begin
					tex_mem[addr_s5] <= data_s5;
				end
			end else begin
				texel_s6 <= tex_mem[addr_s5];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= go_s5 && !wr_s5;
		end
	end

	assign out_valid = vld_s6;
	assign texel     = texel_s6;

	// input only backs up once the first remainder stage is holding an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> div_vld_q[0])
		else $error("input stalled with an empty first stage");

	// a fetch leaving the mapping stage shows up as a result next cycle
	a_fetch_out: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s5 && !wr_s5) |=> out_valid)
		else $error("fetch issued to memory but no result followed");

	// no memory read may replace a result that is still waiting
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !(go_s5 && !wr_s5))
		else $error("memory read while the output item is stalled");

	// a write item never produces a result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s5 && wr_s5 && !out_valid) |=> !out_valid)
		else $error("write item produced a result");

endmodule

FILE: tb/texel_fetch_checker.sv
`timescale 1ns / 100ps
// checker for the texture coordinate wrap block: watches the item, result and register channels
// keeps its own texel store, sizes and wrap mode, predicts every fetched texel and compares
// depends on tcw_pkg
module texel_fetch_checker import tcw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    func,
	input  coord_t                  row,
	input  coord_t                  col,
	input  texel_t                  texel_in,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  texel_t                  texel,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_REG_BITS-1:0] cfg_data,
	input  logic                    drain_done,
	output int                      pending,
	output int                      fails,
	output int                      checked
);

	texel_t texel_mirror [STORE_DEPTH];
	texel_t texel_due_q [$];
	logic [CFG_REG_BITS-1:0] rows_reg;
	logic [CFG_REG_BITS-1:0] cols_reg;
	logic [MODE_BITS-1:0] mode_reg;
	logic drained;

	// 0 counts as 1, anything above the store edge counts as the full edge
	function automatic int size_in_use(input logic [CFG_REG_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > TEX_DIM)
			return TEX_DIM;
		return int'(v);
	endfunction

	function automatic int map_coord(input int c, input int n, input logic [MODE_BITS-1:0] m);
		int r;
		case (m)
			WRAP_REPEAT: return c % n;
			WRAP_MIRROR: begin
				r = c % (2 * n);
				return (r < n) ? r : 2 * n - 1 - r;
			end
			// clamp, and the unused mode code behaves the same
			default: return (c < n) ? c : n - 1;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		int rows;
		int cols;
		int tr;
		int tc;
		if (!arst_n) begin
			rows_reg = 1;
			cols_reg = 1;
			mode_reg = WRAP_CLAMP;
			texel_due_q.delete();
			drained = 1'b0;
			pending = 0;
			fails = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEX_ROWS: rows_reg = cfg_data;
					REG_TEX_COLS: cols_reg = cfg_data;
					REG_WRAP_MODE: mode_reg = cfg_data[MODE_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (texel_due_q.size() == 0) begin
					$error("texel: no item expected, actual %0h", texel);
					fails++;
				end else begin
					want = texel_due_q.pop_front();
					checked++;
					if (texel !== want) begin
						$error("texel: expected %0h, actual %0h", want, texel);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				rows = size_in_use(rows_reg);
				cols = size_in_use(cols_reg);
				if (func == FUNC_FETCH) begin
					tr = map_coord(int'(row), rows, mode_reg);
					tc = map_coord(int'(col), cols, mode_reg);
					texel_due_q.push_back(texel_mirror[tr * TEX_DIM + tc]);
				end else if (int'(row) < rows && int'(col) < cols) begin
					texel_mirror[int'(row) * TEX_DIM + int'(col)] = texel_in;
				end
			end
			if (drain_done && !drained) begin
				drained = 1'b1;
				if (texel_due_q.size() != 0) begin
					$error("texel: %0d expected items never arrived", texel_due_q.size());
					fails += texel_due_q.size();
				end
			end
			pending = texel_due_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// top of the texture coordinate wrap testbench: clock, reset, stimulus, watchdog and verdict
// depends on tcw_pkg, texture_coordinate_wrap_top and texel_fetch_checker
module tb;
	import tcw_pkg::*;

	localparam int LATENCY    = 5;
	localparam int DRAIN_GAP  = LATENCY + 4;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF   = 400;
	localparam int PHASE_ITEMS = 30;
	// edge of the preloaded corner block
	localparam int PRE_DIM    = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_NONE    = 2'd3;
	localparam logic [MODE_BITS-1:0]    WRAP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	coord_t row;
	coord_t col;
	texel_t texel_in;
	logic out_valid;
	logic out_stall;
	texel_t texel;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_REG_BITS-1:0] cfg_data;
	logic drain_done;
	int pending;
	int fails;
	int checked;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_left;
	int cur_rows;
	int cur_cols;
	int n_items;
	int n_cfg;
	int idle_cycles;

	texture_coordinate_wrap_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .row(row), .col(col), .texel_in(texel_in),
		.out_valid(out_valid), .out_stall(out_stall), .texel(texel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	texel_fetch_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .row(row), .col(col), .texel_in(texel_in),
		.out_valid(out_valid), .out_stall(out_stall), .texel(texel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.drain_done(drain_done),
		.pending(pending), .fails(fails), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off while hold_left counts down
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val[CFG_REG_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// writes give no result, so allow the pipeline to empty after the last texel
	task automatic quiesce();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_GAP)
			@(negedge clk);
	endtask

	task automatic setup(input int r, input int c, input logic [MODE_BITS-1:0] m);
		quiesce();
		write_reg(REG_TEX_ROWS, r);
		write_reg(REG_TEX_COLS, c);
		write_reg(REG_WRAP_MODE, m);
		cur_rows = (r < 1) ? 1 : (r > TEX_DIM) ? TEX_DIM : r;
		cur_cols = (c < 1) ? 1 : (c > TEX_DIM) ? TEX_DIM : c;
	endtask

	task automatic set_idle(input int tx, input int rx);
		@(posedge clk);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		@(negedge clk);
	endtask

	task automatic send_item(input logic f, input coord_t r, input coord_t c, input texel_t t);
		// each cycle idles with the sender's idle chance before the item is offered
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		row = r;
		col = c;
		texel_in = t;
		n_items++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly a few periods past the size, now and then near or at the top of the range
	function automatic coord_t pick_coord(input int n);
		case ($urandom_range(9))
			0: return coord_t'($urandom);
			1: return 16'hFFFF - coord_t'($urandom_range(2 * n));
			default: return coord_t'($urandom_range(3 * n));
		endcase
	endfunction

	task automatic rand_item();
		logic f;
		coord_t r;
		coord_t c;
		texel_t t;
		f = ($urandom_range(99) < 65) ? FUNC_FETCH : FUNC_WRITE;
		t = texel_t'($urandom);
		if (f == FUNC_FETCH) begin
			r = pick_coord(cur_rows);
			c = pick_coord(cur_cols);
		end else if ($urandom_range(3) != 0) begin
			r = coord_t'($urandom_range(cur_rows - 1));
			c = coord_t'($urandom_range(cur_cols - 1));
		end else begin
			r = coord_t'($urandom);
			c = coord_t'($urandom);
		end
		send_item(f, r, c, t);
	endtask

	initial begin
		int rr;
		int cc;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		row = '0;
		col = '0;
		texel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEX_ROWS;
		cfg_data = '0;
		drain_done = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		cur_rows = 1;
		cur_cols = 1;
		n_items = 0;
		n_cfg = 0;
		idle_cycles = 0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// write the corner block, the first row and the first column; the sizes used
		// below stay inside them, so no fetch can reach an unwritten texel
		setup(TEX_DIM, TEX_DIM, WRAP_CLAMP);
		for (rr = 0; rr < PRE_DIM; rr++)
			for (cc = 0; cc < PRE_DIM; cc++)
				send_item(FUNC_WRITE, coord_t'(rr), coord_t'(cc), texel_t'($urandom));
		for (cc = PRE_DIM; cc < TEX_DIM; cc++)
			send_item(FUNC_WRITE, coord_t'(0), coord_t'(cc), texel_t'($urandom));
		for (rr = PRE_DIM; rr < TEX_DIM; rr++)
			send_item(FUNC_WRITE, coord_t'(rr), coord_t'(0), texel_t'($urandom));

		// directed: edges of each mode, writes just outside and just inside the size
		setup(5, 3, WRAP_CLAMP);
		send_item(FUNC_FETCH, 16'd0, 16'd0, 8'h00);
		send_item(FUNC_FETCH, 16'd4, 16'd2, 8'h00);
		send_item(FUNC_FETCH, 16'd5, 16'd3, 8'h00);
		send_item(FUNC_FETCH, 16'hFFFF, 16'hFFFF, 8'h00);
		send_item(FUNC_WRITE, 16'd5, 16'd0, 8'h5A);
		send_item(FUNC_WRITE, 16'd0, 16'd3, 8'hA5);
		send_item(FUNC_WRITE, 16'd4, 16'd2, 8'hFF);
		send_item(FUNC_WRITE, 16'd0, 16'd0, 8'h00);
		send_item(FUNC_FETCH, 16'd100, 16'd100, 8'hFF);
		setup(5, 3, WRAP_REPEAT);
		send_item(FUNC_FETCH, 16'd5, 16'd3, 8'h00);
		send_item(FUNC_FETCH, 16'd9, 16'd7, 8'h00);
		send_item(FUNC_FETCH, 16'hFFFF, 16'hFFFF, 8'h00);
		setup(5, 3, WRAP_MIRROR);
		send_item(FUNC_FETCH, 16'd5, 16'd3, 8'h00);
		send_item(FUNC_FETCH, 16'd9, 16'd5, 8'h00);
		send_item(FUNC_FETCH, 16'd10, 16'd6, 8'h00);
		send_item(FUNC_FETCH, 16'hFFFF, 16'hFFFF, 8'h00);
		setup(5, 3, WRAP_UNUSED);
		send_item(FUNC_FETCH, 16'd70, 16'd70, 8'h00);
		// zero rows acts as one, oversized columns act as the full edge
		setup(0, 127, WRAP_REPEAT);
		send_item(FUNC_FETCH, 16'd3, 16'd65, 8'h00);
		send_item(FUNC_WRITE, 16'd1, 16'd0, 8'h3C);
		send_item(FUNC_FETCH, 16'd1, 16'd0, 8'h00);
		quiesce();
		write_reg(REG_NONE, 7'h7F);
		send_item(FUNC_FETCH, 16'd0, 16'd127, 8'h00);

		// random phases, each with its own sizes, mode and idling pattern
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: setup(PRE_DIM, PRE_DIM, WRAP_MIRROR);
				1: setup(1, 1, WRAP_REPEAT);
				2: setup(1, TEX_DIM, WRAP_MIRROR);
				3: setup(TEX_DIM, 1, WRAP_CLAMP);
				4: setup($urandom_range(1, PRE_DIM), $urandom_range(1, PRE_DIM), WRAP_REPEAT);
				5: setup($urandom_range(1, PRE_DIM), $urandom_range(1, PRE_DIM), WRAP_MIRROR);
				// any row register value, a single column
				6: setup($urandom_range(0, 127), $urandom_range(0, 1),
					MODE_BITS'($urandom_range(0, 3)));
				default: setup($urandom_range(1, PRE_DIM), $urandom_range(1, PRE_DIM),
					WRAP_MIRROR);
			endcase
			case (p % 4)
				0: set_idle(0, 0);
				1: set_idle(53, 0);
				2: set_idle(0, 53);
				default: set_idle(16, 16);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				rand_item();
		end

		// long receiver hold-off while fetches keep coming, so the input backs up
		setup(PRE_DIM, PRE_DIM, WRAP_REPEAT);
		set_idle(0, 0);
		@(posedge clk);
		hold_left = HOLD_OFF;
		@(negedge clk);
		for (int i = 0; i < 80; i++)
			send_item(FUNC_FETCH, pick_coord(PRE_DIM), pick_coord(PRE_DIM), 8'h00);

		quiesce();
		drain_done = 1'b1;
		@(negedge clk);
		@(negedge clk);
		$display("%0d items sent (store preload included), %0d register writes", n_items, n_cfg);
		$display("%0d fetched texels compared over clamp, repeat, mirrored and unused modes",
			checked);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/tcw_pkg.sv
sv/tcw_rem_pipe.sv
sv/texture_coordinate_wrap_top.sv
tb/texel_fetch_checker.sv
tb/tb.sv
